// ----- hdl/srm_pkg.sv -----
// Shared types and constants for the spiral order matrix reader.
`timescale 1ns / 1ps
`default_nettype none
package srm_pkg;

  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET = CFG_W'(4);
  localparam logic [CFG_W-1:0] COL_COUNT_RESET = CFG_W'(4);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } srm_state_e;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } srm_dir_e;

  typedef struct packed {
    logic             final_beat;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
  } srm_job_t;

  function automatic logic [CFG_W-1:0] eff_count(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/srm_queue.sv -----
// Two-entry first-in first-out queue of beats.
`timescale 1ns / 1ps
`default_nettype none
module srm_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] pop_data_o,
  output      logic             empty_o,
  output      logic [1:0]       count_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign count_o    = count_q;
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/srm_front.sv -----
// Front end: configuration registers, load counter and beat classification.
`timescale 1ns / 1ps
`default_nettype none
module srm_front #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8,
  parameter int AW       = 6,
  parameter int CNTW     = 7
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [srm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [srm_pkg::CFG_W-1:0]    cfg_data_i,
  input  wire logic                         in_valid_i,
  input  wire logic [srm_pkg::DATA_W-1:0]   in_data_i,
  output      logic                         in_stall_o,
  input  wire logic                         q_full_i,
  output      logic                         q_push_o,
  output      srm_pkg::srm_job_t            q_job_o,
  output      logic [AW-1:0]                q_addr_o,
  output      logic [srm_pkg::DATA_W-1:0]   q_data_o
);
  import srm_pkg::*;

  localparam int CMPW = CNTW + 2 * CFG_W;

  logic [CFG_W-1:0]   row_q, col_q;
  logic [CNTW-1:0]    load_q, load_d;
  logic [CFG_W-1:0]   rows, cols;
  logic [2*CFG_W-1:0] total;
  logic [CNTW-1:0]    next_count;
  logic               final_beat;
  logic               accept;

  assign rows       = eff_count(row_q, CFG_W'(MAX_ROWS));
  assign cols       = eff_count(col_q, CFG_W'(MAX_COLS));
  assign total      = (2*CFG_W)'(rows) * (2*CFG_W)'(cols);
  assign next_count = load_q + CNTW'(1);
  assign final_beat = (CMPW'(next_count) >= CMPW'(total));
  assign accept     = in_valid_i && !q_full_i;

  assign in_stall_o         = q_full_i;
  assign q_push_o           = accept;
  assign q_job_o.final_beat = final_beat;
  assign q_job_o.rows       = rows;
  assign q_job_o.cols       = cols;
  assign q_addr_o           = load_q[AW-1:0];
  assign q_data_o           = in_data_i;

  always_comb begin
    load_d = load_q;
    if (accept) begin
      load_d = final_beat ? '0 : next_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      row_q  <= ROW_COUNT_RESET;
      col_q  <= COL_COUNT_RESET;
    end else begin
      load_q <= load_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ROW_COUNT: row_q <= cfg_data_i;
          REG_COL_COUNT: col_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/srm_back.sv -----
// Back end: element store, spiral address walker and result queue.
`timescale 1ns / 1ps
`default_nettype none
module srm_back #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8,
  parameter int AW       = 6,
  parameter int CNTW     = 7
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cmd_empty_i,
  output      logic                       cmd_pop_o,
  input  wire srm_pkg::srm_job_t          cmd_job_i,
  input  wire logic [AW-1:0]              cmd_addr_i,
  input  wire logic [srm_pkg::DATA_W-1:0] cmd_data_i,
  input  wire logic                       out_stall_i,
  output      logic                       out_valid_o,
  output      logic [srm_pkg::DATA_W-1:0] out_value_o,
  output      logic                       out_last_o
);
  import srm_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int FW    = AW + CFG_W + 1;
  localparam int OW    = DATA_W + 1;

  logic [DATA_W-1:0] mem [DEPTH];

  srm_state_e       state_q, state_d;
  srm_dir_e         dir_q, dir_d;
  logic [RW-1:0]    r_q, r_d, top_q, top_d, bot_q, bot_d;
  logic [CW-1:0]    c_q, c_d, lft_q, lft_d, rgt_q, rgt_d;
  logic [CFG_W-1:0] cols_q, cols_d;
  logic [CNTW-1:0]  rem_q, rem_d;

  logic [2*CFG_W-1:0] job_total;
  logic [FW-1:0]      addr_full;
  logic [AW-1:0]      rd_addr;
  logic               rd_en;
  logic               mem_we;
  logic               rd_vld_q, rd_last_q;
  logic [DATA_W-1:0]  rd_data_q;

  logic               oq_full, oq_empty, oq_pop;
  logic [1:0]         oq_count;
  logic [2:0]         occ;
  logic               can_issue;
  logic [OW-1:0]      oq_data;

  assign job_total = (2*CFG_W)'(cmd_job_i.rows) * (2*CFG_W)'(cmd_job_i.cols);
  assign addr_full = FW'(r_q) * FW'(cols_q) + FW'(c_q);
  assign rd_addr   = addr_full[AW-1:0];

  assign oq_pop    = !oq_empty && !out_stall_i;
  assign occ       = 3'(oq_count) + 3'(rd_vld_q);
  assign can_issue = oq_pop ? (occ <= 3'd2) : (occ <= 3'd1);

  always_comb begin
    state_d   = state_q;
    dir_d     = dir_q;
    r_d       = r_q;
    c_d       = c_q;
    top_d     = top_q;
    bot_d     = bot_q;
    lft_d     = lft_q;
    rgt_d     = rgt_q;
    cols_d    = cols_q;
    rem_d     = rem_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          mem_we    = 1'b1;
          if (cmd_job_i.final_beat) begin
            state_d = ST_WALK;
            dir_d   = DIR_RIGHT;
            r_d     = '0;
            c_d     = '0;
            top_d   = '0;
            lft_d   = '0;
            bot_d   = RW'(cmd_job_i.rows - CFG_W'(1));
            rgt_d   = CW'(cmd_job_i.cols - CFG_W'(1));
            cols_d  = cmd_job_i.cols;
            rem_d   = CNTW'(job_total);
          end
        end
      end
      ST_WALK: begin
        if (can_issue) begin
          rd_en = 1'b1;
          rem_d = rem_q - CNTW'(1);
          if (rem_q == CNTW'(1)) begin
            state_d = ST_IDLE;
          end
          case (dir_q)
            DIR_RIGHT: begin
              if (c_q == rgt_q) begin
                top_d = top_q + RW'(1);
                r_d   = r_q + RW'(1);
                dir_d = DIR_DOWN;
              end else begin
                c_d = c_q + CW'(1);
              end
            end
            DIR_DOWN: begin
              if (r_q == bot_q) begin
                rgt_d = rgt_q - CW'(1);
                c_d   = c_q - CW'(1);
                dir_d = DIR_LEFT;
              end else begin
                r_d = r_q + RW'(1);
              end
            end
            DIR_LEFT: begin
              if (c_q == lft_q) begin
                bot_d = bot_q - RW'(1);
                r_d   = r_q - RW'(1);
                dir_d = DIR_UP;
              end else begin
                c_d = c_q - CW'(1);
              end
            end
            DIR_UP: begin
              if (r_q == top_q) begin
                lft_d = lft_q + CW'(1);
                c_d   = c_q + CW'(1);
                dir_d = DIR_RIGHT;
              end else begin
                r_d = r_q - RW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      dir_q     <= DIR_RIGHT;
      rem_q     <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      dir_q     <= dir_d;
      rem_q     <= rem_d;
      rd_vld_q  <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q       <= r_d;
    c_q       <= c_d;
    top_q     <= top_d;
    bot_q     <= bot_d;
    lft_q     <= lft_d;
    rgt_q     <= rgt_d;
    cols_q    <= cols_d;
    rd_last_q <= (rem_q == CNTW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cmd_addr_i] <= cmd_data_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  srm_queue #(
    .WIDTH(OW)
  ) u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (rd_vld_q),
    .push_data_i({rd_last_q, rd_data_q}),
    .full_o     (oq_full),
    .pop_i      (oq_pop),
    .pop_data_o (oq_data),
    .empty_o    (oq_empty),
    .count_o    (oq_count)
  );

  assign out_valid_o = !oq_empty && !(oq_full && 1'b0);
  assign out_value_o = oq_data[DATA_W-1:0];
  assign out_last_o  = oq_data[DATA_W];

endmodule
`default_nettype wire

// ----- hdl/spiral_order_matrix_reader.sv -----
// Top level of the spiral order matrix reader.
// Loading: one element beat per cycle while the command queue has room.
// A matrix of N elements is read out one result per cycle while out_stall_i is low;
// the first result follows the final beat via the command queue, read register and output queue.
// Input stalls while the back end walks the spiral and the command queue fills.
// Reset clears the load counter, queues and walker; the counts return to 4.
`timescale 1ns / 1ps
`default_nettype none
module spiral_order_matrix_reader #(
  parameter int MAX_ROWS = 8,
  parameter int MAX_COLS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [srm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [srm_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic signed [srm_pkg::DATA_W-1:0] element_value_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic signed [srm_pkg::DATA_W-1:0] out_value_o,
  output      logic                          last_of_run_o
);
  import srm_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int JW    = $bits(srm_job_t);
  localparam int QW    = JW + AW + DATA_W;

  logic              f_push, q_full, q_empty, q_pop;
  srm_job_t          f_job, b_job;
  logic [AW-1:0]     f_addr;
  logic [DATA_W-1:0] f_data;
  logic [QW-1:0]     q_out;
  logic [1:0]        q_count;
  logic [DATA_W-1:0] b_value;

  assign cfg_ready_o = 1'b1;

  srm_front #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .AW      (AW),
    .CNTW    (CNTW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (element_value_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (f_push),
    .q_job_o    (f_job),
    .q_addr_o   (f_addr),
    .q_data_o   (f_data)
  );

  srm_queue #(
    .WIDTH(QW)
  ) u_cmd_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (f_push),
    .push_data_i({f_job, f_addr, f_data}),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_data_o (q_out),
    .empty_o    (q_empty),
    .count_o    (q_count)
  );

  assign b_job = q_out[QW-1 -: JW];

  srm_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .AW      (AW),
    .CNTW    (CNTW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(q_empty && (q_count == 2'd0)),
    .cmd_pop_o  (q_pop),
    .cmd_job_i  (b_job),
    .cmd_addr_i (q_out[DATA_W +: AW]),
    .cmd_data_i (q_out[DATA_W-1:0]),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_value_o(b_value),
    .out_last_o (last_of_run_o)
  );

  assign out_value_o = b_value;

endmodule
`default_nettype wire

// ----- test/tb_spiral_order_matrix_reader.sv -----
// Self-checking testbench for the spiral order matrix reader with random flow control.
`timescale 1ns / 1ps
module tb_spiral_order_matrix_reader;
  import srm_pkg::*;

  localparam int ITEMS     = 310;
  localparam int MAX_DIM   = 8;
  localparam int HOLD_LEN  = 400;
  localparam int IDLE_WAIT = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TOP = '1;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } spiral_beat_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_W-1:0]         cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] element_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] out_value_o;
  logic                     last_of_run_o;

  logic [DATA_W-1:0] element_q[$];
  spiral_beat_t      spiral_q[$];
  logic [DATA_W-1:0] mat_store[64];
  logic [6:0]        load_cnt = '0;
  logic [CFG_W-1:0]  row_reg = ROW_COUNT_RESET;
  logic [CFG_W-1:0]  col_reg = COL_COUNT_RESET;
  logic              in_fire = 1'b0;
  int                burst_left = 1;
  int                gap_left = 0;
  int                hold_asked = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  logic [15:0]       stall_tick = '0;
  int                errors = 0;
  int                sent = 0;

  spiral_order_matrix_reader #(
    .MAX_ROWS(MAX_DIM),
    .MAX_COLS(MAX_DIM)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_value_o    (out_value_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int clip_count(input logic [CFG_W-1:0] v);
    int n;
    n = int'(v);
    if (n == 0) begin
      n = 1;
    end else if (n > MAX_DIM) begin
      n = MAX_DIM;
    end
    return n;
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    logic [CFG_W-1:0] v;
    if ($urandom_range(0, 7) == 0) begin
      v = ($urandom_range(0, 1) == 0) ? '0 : CFG_W'($urandom_range(MAX_DIM + 1, 15));
    end else begin
      v = CFG_W'($urandom_range(1, MAX_DIM));
    end
    return v;
  endfunction

  // store one element; on the completing one, walk the matrix clockwise
  task automatic absorb_element(input logic [DATA_W-1:0] v);
    int rows, cols, total, top, bottom, left, right, r, c, i;
    logic [DATA_W-1:0] walk[$];
    spiral_beat_t beat;
    rows  = clip_count(row_reg);
    cols  = clip_count(col_reg);
    total = rows * cols;
    mat_store[load_cnt[5:0]] = v;
    load_cnt = load_cnt + 7'd1;
    if (load_cnt != 0 && load_cnt < total) begin
      return;
    end
    top = 0;
    bottom = rows - 1;
    left = 0;
    right = cols - 1;
    while (top <= bottom && left <= right) begin
      for (c = left; c <= right; c++) walk = {walk, mat_store[6'(top * cols + c)]};
      for (r = top + 1; r <= bottom; r++) walk = {walk, mat_store[6'(r * cols + right)]};
      if (top < bottom && left < right) begin
        for (c = right - 1; c >= left; c--) walk = {walk, mat_store[6'(bottom * cols + c)]};
        for (r = bottom - 1; r > top; r--) walk = {walk, mat_store[6'(r * cols + left)]};
      end
      top++;
      bottom--;
      left++;
      right--;
    end
    for (i = 0; i < walk.size(); i++) begin
      beat.value = walk[i];
      beat.last  = (i == walk.size() - 1);
      spiral_q = {spiral_q, beat};
    end
    load_cnt = '0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_ROW_COUNT) begin
      row_reg = val;
    end else if (idx == REG_COL_COUNT) begin
      col_reg = val;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_random(input int n);
    repeat (n) element_q = {element_q, $urandom};
    sent += n;
  endtask

  task automatic queue_value(input logic [DATA_W-1:0] v);
    element_q = {element_q, v};
    sent++;
  endtask

  // hold until every element is taken and every spiral beat has come out
  task automatic drain();
    while (element_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (spiral_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) begin
      absorb_element(element_value_i);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (element_q.size() != 0) begin
        in_valid_i      <= 1'b1;
        element_value_i <= element_q.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 16'd1;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_asked != hold_seen) begin
      out_stall_i <= 1'b1;
      hold_seen   <= hold_asked;
      hold_left   <= HOLD_LEN;
    end else begin
      case (stall_tick[8:6])
        3'd2, 3'd3: out_stall_i <= ($urandom_range(0, 3) == 0);
        3'd4: out_stall_i <= ($urandom_range(0, 3) != 0);
        3'd5: out_stall_i <= stall_tick[0];
        3'd6: out_stall_i <= (stall_tick[3:2] == 2'd3);
        3'd7: out_stall_i <= 1'($urandom_range(0, 1));
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    spiral_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (spiral_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got value %h last %b",
                 $time, out_value_o, last_of_run_o);
        errors++;
      end else begin
        want = spiral_q.pop_front();
        if (out_value_o !== want.value) begin
          $display("%0t: out_value expected %h got %h", $time, want.value, out_value_o);
          errors++;
        end
        if (last_of_run_o !== want.last) begin
          $display("%0t: last_of_run expected %b got %b", $time, want.last, last_of_run_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int n_mat, total, k;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset counts: 4 x 4 with extreme values
    queue_value(32'h8000_0000);
    queue_value(32'h7FFF_FFFF);
    queue_value(32'h0000_0000);
    queue_value(32'hFFFF_FFFF);
    queue_value(32'h0000_0001);
    queue_value(32'h5555_5555);
    queue_value(32'hAAAA_AAAA);
    queue_value(32'hFFFF_FFFE);
    queue_random(8);
    drain();

    // zero counts act as one
    write_reg(REG_ROW_COUNT, '0);
    write_reg(REG_COL_COUNT, '0);
    write_reg(REG_TOP, '1);
    queue_value(32'h8000_0000);
    queue_value(32'h7FFF_FFFF);
    drain();

    // oversized row count clips to a single column of eight
    write_reg(REG_ROW_COUNT, '1);
    queue_random(8);
    drain();

    // long receiver hold-off while several matrices queue up
    write_reg(REG_ROW_COUNT, CFG_W'(3));
    write_reg(REG_COL_COUNT, CFG_W'(3));
    hold_asked++;
    queue_random(45);
    drain();

    write_reg(REG_ROW_COUNT, CFG_W'(MAX_DIM));
    write_reg(REG_COL_COUNT, CFG_W'(MAX_DIM));
    queue_random(MAX_DIM * MAX_DIM);
    drain();

    while (sent < ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_COL_COUNT + 1, REG_TOP)), CFG_W'($urandom));
      end
      write_reg(REG_ROW_COUNT, pick_count());
      write_reg(REG_COL_COUNT, pick_count());
      total = clip_count(row_reg) * clip_count(col_reg);
      n_mat = $urandom_range(1, 3);
      k = total - int'(load_cnt);
      if (k < 1) begin
        k = 1;
      end
      queue_random(k);
      queue_random((n_mat - 1) * total);
      // leave a load part done so the next counts apply mid-matrix
      if (total > 1 && $urandom_range(0, 4) == 0) begin
        queue_random($urandom_range(1, total - 1));
      end
      drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && spiral_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
